// ===== design/ssrq_pkg.sv =====
`default_nettype none

package ssrq_pkg;

    localparam int SECTOR_W = 48;
    localparam int TAG_W    = 8;
    localparam int OCC_W    = 5;

    localparam logic [1:0] MODE_INSERT   = 2'd0;
    localparam logic [1:0] MODE_DISPATCH = 2'd1;
    localparam logic [1:0] MODE_REMOVE   = 2'd2;
    localparam logic [1:0] MODE_NOP      = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_NOTAG = 2'd3;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [TAG_W-1:0]    tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

// ===== design/ssrq_ram.sv =====
`default_nettype none

module ssrq_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== design/sector_sorted_request_queue_unit.sv =====
`default_nettype none

// Sorted request queue: keeps up to QUEUE_DEPTH requests (sector, tag) in ascending
// sector order in a single RAM with one write and one registered read port. One
// sequencer walks the stored entries one per cycle through a shared sector compare
// and tag match. An insert walks from the tail toward the head, moving each larger
// entry up one slot until the new request drops in; a dispatch or remove walks from
// the head, finds the entry and moves every later entry down one slot. A transaction
// passes from acceptance through a start state, which sends full, empty and no-op
// cases straight to the result state or else issues the first read, then the walk, then
// a write state for a new request that lands at the head or in an empty queue, and the
// result state. A new transaction is accepted as soon as the sequencer is
// idle, even while the previous result waits in the output register.
module sector_sorted_request_queue_unit
    import ssrq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [1:0]          i_mode,
    input  wire logic [SECTOR_W-1:0] i_sector,
    input  wire logic [TAG_W-1:0]    i_tag,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic      [1:0]          o_status,
    output logic      [SECTOR_W-1:0] o_out_sector,
    output logic      [TAG_W-1:0]    o_out_tag,
    output logic      [OCC_W-1:0]    o_occupancy
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_INS   = 3'd2;
    localparam logic [2:0] S_WNEW  = 3'd3;
    localparam logic [2:0] S_REM   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_ptr, n_ptr;
    logic [AW-1:0]       r_wpos, n_wpos;
    logic                r_found, n_found;
    logic [1:0]          r_mode, n_mode;
    logic [SECTOR_W-1:0] r_sector, n_sector;
    logic [TAG_W-1:0]    r_tag, n_tag;
    logic [1:0]          r_status, n_status;
    t_entry              r_res, n_res;

    logic                r_out_vld, n_out_vld;
    logic [1:0]          r_o_status, n_o_status;
    t_entry              r_o_res, n_o_res;
    logic [OCC_W-1:0]    r_o_occ, n_o_occ;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    t_entry              wr_data;
    logic [AW-1:0]       rd_addr;
    logic [ENTRY_W-1:0]  rd_bits;
    t_entry              rd_entry;
    t_entry              new_entry;
    logic [AW-1:0]       last_idx;
    logic                sec_greater;
    logic                hit;
    logic                load_out;

    ssrq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_bits)
    );

    assign rd_entry  = t_entry'(rd_bits);
    assign new_entry = '{sector: r_sector, tag: r_tag};
    assign last_idx  = AW'(r_count - 1'b1);

    // The shared compare unit: sector order for inserts, tag match for removes, head slot for dispatches.
    assign sec_greater = rd_entry.sector > r_sector;
    assign hit = !r_found && ((r_mode == MODE_DISPATCH) ? (r_ptr == '0)
                                                        : (rd_entry.tag == r_tag));

    assign o_in_ready = (r_state == S_IDLE);
    assign load_out   = (r_state == S_OUT) && (!r_out_vld || i_out_ready);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_wpos   = r_wpos;
        n_found  = r_found;
        n_mode   = r_mode;
        n_sector = r_sector;
        n_tag    = r_tag;
        n_status = r_status;
        n_res    = r_res;
        wr_en    = 1'b0;
        wr_addr  = r_wpos;
        wr_data  = new_entry;
        rd_addr  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode   = i_mode;
                    n_sector = i_sector;
                    n_tag    = i_tag;
                    n_status = ST_OK;
                    n_res    = '0;
                    n_found  = 1'b0;
                    n_state  = S_START;
                end
            end
            S_START: begin
                unique case (r_mode)
                    MODE_INSERT: begin
                        if (r_count == CW'(QUEUE_DEPTH)) begin
                            n_status = ST_FULL;
                            n_state  = S_OUT;
                        end else if (r_count == '0) begin
                            n_wpos  = '0;
                            n_state = S_WNEW;
                        end else begin
                            rd_addr = last_idx;
                            n_ptr   = last_idx;
                            n_state = S_INS;
                        end
                    end
                    MODE_DISPATCH, MODE_REMOVE: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_OUT;
                        end else begin
                            rd_addr = '0;
                            n_ptr   = '0;
                            n_state = S_REM;
                        end
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_INS: begin
                // Walking from the tail: larger entries move up one slot.
                wr_en   = 1'b1;
                wr_addr = r_ptr + 1'b1;
                if (sec_greater) begin
                    wr_data = rd_entry;
                    if (r_ptr == '0) begin
                        n_wpos  = '0;
                        n_state = S_WNEW;
                    end else begin
                        rd_addr = r_ptr - 1'b1;
                        n_ptr   = r_ptr - 1'b1;
                    end
                end else begin
                    wr_data = new_entry;
                    n_count = r_count + 1'b1;
                    n_state = S_OUT;
                end
            end
            S_WNEW: begin
                wr_en   = 1'b1;
                wr_addr = r_wpos;
                wr_data = new_entry;
                n_count = r_count + 1'b1;
                n_state = S_OUT;
            end
            S_REM: begin
                // After the match every later entry closes the gap by one slot.
                if (r_found) begin
                    wr_en   = 1'b1;
                    wr_addr = r_ptr - 1'b1;
                    wr_data = rd_entry;
                end
                if (hit) begin
                    n_found = 1'b1;
                    n_res   = rd_entry;
                end
                if (r_ptr == last_idx) begin
                    if (r_found || hit) begin
                        n_count = r_count - 1'b1;
                    end else begin
                        n_status = ST_NOTAG;
                    end
                    n_state = S_OUT;
                end else begin
                    rd_addr = r_ptr + 1'b1;
                    n_ptr   = r_ptr + 1'b1;
                end
            end
            S_OUT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld  = r_out_vld;
        n_o_status = r_o_status;
        n_o_res    = r_o_res;
        n_o_occ    = r_o_occ;
        if (load_out) begin
            n_out_vld  = 1'b1;
            n_o_status = r_status;
            n_o_res    = r_res;
            n_o_occ    = OCC_W'(r_count);
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_found   <= n_found;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_wpos     <= n_wpos;
        r_mode     <= n_mode;
        r_sector   <= n_sector;
        r_tag      <= n_tag;
        r_status   <= n_status;
        r_res      <= n_res;
        r_o_status <= n_o_status;
        r_o_res    <= n_o_res;
        r_o_occ    <= n_o_occ;
    end

    assign o_out_valid  = r_out_vld;
    assign o_status     = r_o_status;
    assign o_out_sector = r_o_res.sector;
    assign o_out_tag    = r_o_res.tag;
    assign o_occupancy  = r_o_occ;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_START))
        else $error("accepted transaction did not start the sequencer");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_status == ST_FULL) |-> (r_count == CW'(QUEUE_DEPTH)))
        else $error("full status reported while queue not full");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_status == ST_EMPTY) |-> (r_count == '0))
        else $error("empty status reported while queue holds entries");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_out_sector == '0 && o_out_tag == '0))
        else $error("failed transaction reports a nonzero entry");

endmodule

`default_nettype wire
